### hw/rtl/mac_pkg.sv
// types, constants and helpers shared by the attractor classifier modules
package mac_pkg;

	localparam int FRAC_BITS = 28;
	localparam int TWICE_SHIFT = FRAC_BITS - 1;
	localparam int ESC_SHIFT = 2 * FRAC_BITS;

	localparam logic signed [31:0] DERIV_ONE = 32'sh0100_0000;

	localparam logic [7:0] GRAY_INSIDE = 8'd220;
	localparam logic [7:0] GRAY_ESCAPED = 8'd255;

	localparam logic [1:0] CLASS_ESCAPED = 2'd0;
	localparam logic [1:0] CLASS_CYCLE = 2'd1;
	localparam logic [1:0] CLASS_LIMIT = 2'd2;

	localparam logic [2:0] CFG_START_RE = 3'd0;
	localparam logic [2:0] CFG_START_IM = 3'd1;
	localparam logic [2:0] CFG_PIXEL_STEP = 3'd2;
	localparam logic [2:0] CFG_ESCAPE_SQ = 3'd3;
	localparam logic [2:0] CFG_MAX_ITER = 3'd4;
	localparam logic [2:0] CFG_EPS_SQ = 3'd5;

	// setup phases
	localparam logic [3:0] PH_SET_RE = 4'd0;
	localparam logic [3:0] PH_SET_IM = 4'd1;
	localparam logic [3:0] PH_SET_LAST = 4'd2;

	// iteration phases, named after the product issued in that phase
	localparam logic [3:0] PH_DRE2 = 4'd0;
	localparam logic [3:0] PH_DIM2 = 4'd1;
	localparam logic [3:0] PH_ZRE2 = 4'd2;
	localparam logic [3:0] PH_ZIM2 = 4'd3;
	localparam logic [3:0] PH_DRE_ZRE = 4'd4;
	localparam logic [3:0] PH_DIM_ZIM = 4'd5;
	localparam logic [3:0] PH_DRE_ZIM = 4'd6;
	localparam logic [3:0] PH_DIM_ZRE = 4'd7;
	localparam logic [3:0] PH_ZRE_ZIM = 4'd8;
	localparam logic [3:0] PH_LAST = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ITER,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [10:0] column;
		logic [9:0] row;
	} pixel_t;

	typedef struct packed {
		logic [15:0] iterations;
		logic [1:0] point_class;
		logic [7:0] gray;
	} result_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic iter;
		logic commit;
		logic [3:0] phase;
	} ctrl_t;

	typedef struct packed {
		logic cycle_hit;
		logic escaped;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -66'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/mac_mul.sv
// shared signed 32x32 multiplier with registered product
module mac_mul (
	input  logic               clk,
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	output logic signed [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

### hw/rtl/mac_ctrl.sv
// sequencer: phase counter, iteration count, decisions and result register
module mac_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pixel_valid,
	output logic            pixel_ready,
	input  logic [15:0]     max_iter,
	input  mac_pkg::stat_t  st,
	output mac_pkg::ctrl_t  ctl,
	output logic            result_valid,
	input  logic            result_ready,
	output mac_pkg::result_t result
);

	mac_pkg::state_t state_q, state_d;
	logic [3:0] phase_q, phase_d;
	logic [15:0] n_q, n_d;
	logic [15:0] n_inc;
	logic fin_set;
	logic [15:0] fin_iter_q, fin_iter_d;
	logic [1:0] fin_cls_q, fin_cls_d;
	logic out_load;
	logic out_valid_q;
	mac_pkg::result_t res_q;

	assign n_inc = n_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mac_pkg::ST_IDLE;
			phase_q <= 4'd0;
			n_q <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			n_q <= n_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_set) begin
			fin_iter_q <= fin_iter_d;
			fin_cls_q <= fin_cls_d;
		end
		if (out_load) begin
			res_q.iterations <= fin_iter_q;
			res_q.point_class <= fin_cls_q;
			res_q.gray <= (fin_cls_q == mac_pkg::CLASS_ESCAPED) ?
				mac_pkg::GRAY_ESCAPED : mac_pkg::GRAY_INSIDE;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		n_d = n_q;
		fin_set = 1'b0;
		fin_iter_d = n_q;
		fin_cls_d = mac_pkg::CLASS_LIMIT;
		out_load = 1'b0;
		pixel_ready = 1'b0;
		ctl = '0;
		ctl.phase = phase_q;
		case (state_q)
			mac_pkg::ST_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid) begin
					ctl.load = 1'b1;
					phase_d = mac_pkg::PH_SET_RE;
					state_d = mac_pkg::ST_SETUP;
				end
			end
			mac_pkg::ST_SETUP: begin
				ctl.setup = 1'b1;
				if (phase_q == mac_pkg::PH_SET_LAST) begin
					phase_d = mac_pkg::PH_DRE2;
					n_d = 16'd0;
					if (max_iter == 16'd0) begin
						fin_set = 1'b1;
						fin_iter_d = 16'd0;
						fin_cls_d = mac_pkg::CLASS_LIMIT;
						state_d = mac_pkg::ST_FINISH;
					end else begin
						state_d = mac_pkg::ST_ITER;
					end
				end else begin
					phase_d = phase_q + 4'd1;
				end
			end
			mac_pkg::ST_ITER: begin
				ctl.iter = 1'b1;
				if (phase_q == mac_pkg::PH_LAST) begin
					phase_d = mac_pkg::PH_DRE2;
					if (st.cycle_hit) begin
						fin_set = 1'b1;
						fin_iter_d = n_q;
						fin_cls_d = mac_pkg::CLASS_CYCLE;
						state_d = mac_pkg::ST_FINISH;
					end else if (st.escaped) begin
						fin_set = 1'b1;
						fin_iter_d = n_q;
						fin_cls_d = mac_pkg::CLASS_ESCAPED;
						state_d = mac_pkg::ST_FINISH;
					end else begin
						ctl.commit = 1'b1;
						n_d = n_inc;
						if (n_inc == max_iter) begin
							fin_set = 1'b1;
							fin_iter_d = n_inc;
							fin_cls_d = mac_pkg::CLASS_LIMIT;
							state_d = mac_pkg::ST_FINISH;
						end
					end
				end else begin
					phase_d = phase_q + 4'd1;
				end
			end
			mac_pkg::ST_FINISH: begin
				if (!out_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d = mac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mac_pkg::ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result = res_q;

endmodule

### hw/rtl/mac_dpath.sv
// datapath: operand select, accumulation, saturation and the z, d and c registers
module mac_dpath (
	input  logic               clk,
	input  mac_pkg::ctrl_t     ctl,
	input  mac_pkg::pixel_t    pixel,
	input  logic signed [31:0] start_re,
	input  logic signed [31:0] start_im,
	input  logic [30:0]        pixel_step,
	input  logic [3:0]         escape_sq,
	input  logic [47:0]        eps_sq,
	output logic signed [31:0] op_a,
	output logic signed [31:0] op_b,
	input  logic signed [63:0] prod_q,
	output mac_pkg::stat_t     st
);

	logic [10:0] col_q;
	logic [9:0] row_q;
	logic signed [31:0] cre_q, cim_q, zre_q, zim_q, dre_q, dim_q;
	logic signed [31:0] nzre_q, ndre_q, ndim_q;
	logic signed [63:0] acc_q, zdiff_q;
	logic [63:0] dsq_q, zsq_q;
	logic signed [31:0] c_re_new, c_im_new, nzre_new, ndre_new, ndim_new, nzim_new;
	logic signed [64:0] d_diff, d_sum;
	logic [63:0] esc_limit;

	always_comb begin
		op_a = zre_q;
		op_b = zim_q;
		if (ctl.setup) begin
			op_a = signed'({1'b0, pixel_step});
			case (ctl.phase)
				mac_pkg::PH_SET_RE: op_b = signed'({21'd0, col_q});
				default:            op_b = signed'({22'd0, row_q});
			endcase
		end else begin
			case (ctl.phase)
				mac_pkg::PH_DRE2: begin
					op_a = dre_q;
					op_b = dre_q;
				end
				mac_pkg::PH_DIM2: begin
					op_a = dim_q;
					op_b = dim_q;
				end
				mac_pkg::PH_ZRE2: begin
					op_a = zre_q;
					op_b = zre_q;
				end
				mac_pkg::PH_ZIM2: begin
					op_a = zim_q;
					op_b = zim_q;
				end
				mac_pkg::PH_DRE_ZRE: begin
					op_a = dre_q;
					op_b = zre_q;
				end
				mac_pkg::PH_DIM_ZIM: begin
					op_a = dim_q;
					op_b = zim_q;
				end
				mac_pkg::PH_DRE_ZIM: begin
					op_a = dre_q;
					op_b = zim_q;
				end
				mac_pkg::PH_DIM_ZRE: begin
					op_a = dim_q;
					op_b = zre_q;
				end
				default: begin
					op_a = zre_q;
					op_b = zim_q;
				end
			endcase
		end
	end

	assign c_re_new = mac_pkg::sat32(66'(start_re) + 66'(prod_q));
	assign c_im_new = mac_pkg::sat32(66'(start_im) + 66'(prod_q));
	assign d_diff = 65'(acc_q) - 65'(prod_q);
	assign d_sum = 65'(acc_q) + 65'(prod_q);
	assign ndre_new = mac_pkg::sat32(66'(d_diff >>> mac_pkg::TWICE_SHIFT));
	assign ndim_new = mac_pkg::sat32(66'(d_sum >>> mac_pkg::TWICE_SHIFT));
	assign nzre_new = mac_pkg::sat32(66'(zdiff_q >>> mac_pkg::FRAC_BITS) + 66'(cre_q));
	assign nzim_new = mac_pkg::sat32(66'(prod_q >>> mac_pkg::TWICE_SHIFT) + 66'(cim_q));
	assign esc_limit = 64'(escape_sq) << mac_pkg::ESC_SHIFT;

	assign st.cycle_hit = dsq_q < {16'd0, eps_sq};
	assign st.escaped = zsq_q > esc_limit;

	// each phase consumes the product issued in the phase before it
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			col_q <= pixel.column;
			row_q <= pixel.row;
			dre_q <= mac_pkg::DERIV_ONE;
			dim_q <= 32'sd0;
		end
		if (ctl.setup) begin
			case (ctl.phase)
				mac_pkg::PH_SET_IM: begin
					cre_q <= c_re_new;
					zre_q <= c_re_new;
				end
				mac_pkg::PH_SET_LAST: begin
					cim_q <= c_im_new;
					zim_q <= c_im_new;
				end
				default: begin
				end
			endcase
		end
		if (ctl.iter) begin
			case (ctl.phase)
				mac_pkg::PH_DIM2: acc_q <= prod_q;
				mac_pkg::PH_ZRE2: dsq_q <= $unsigned(acc_q) + $unsigned(prod_q);
				mac_pkg::PH_ZIM2: acc_q <= prod_q;
				mac_pkg::PH_DRE_ZRE: begin
					zsq_q <= $unsigned(acc_q) + $unsigned(prod_q);
					zdiff_q <= acc_q - prod_q;
				end
				mac_pkg::PH_DIM_ZIM: begin
					acc_q <= prod_q;
					nzre_q <= nzre_new;
				end
				mac_pkg::PH_DRE_ZIM: ndre_q <= ndre_new;
				mac_pkg::PH_DIM_ZRE: acc_q <= prod_q;
				mac_pkg::PH_ZRE_ZIM: ndim_q <= ndim_new;
				mac_pkg::PH_LAST: begin
					if (ctl.commit) begin
						dre_q <= ndre_q;
						dim_q <= ndim_q;
						zre_q <= nzre_q;
						zim_q <= nzim_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hw/rtl/mandelbrot_attractor_classifier.sv
// top level: configuration registers, sequencer, datapath and shared multiplier
// the single shared multiplier serves nine products per iteration, so a new pixel is
// taken only once the last result is loaded; pixel_ready is low while a pixel is in work
// reset: configuration returns to its defaults, sequencer idle, no result pending
module mandelbrot_attractor_classifier (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  mac_pkg::pixel_t  pixel,
	output logic             result_valid,
	input  logic             result_ready,
	output mac_pkg::result_t result,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [47:0]      wr_data
);

	logic signed [31:0] start_re_q, start_im_q;
	logic [30:0] pixel_step_q;
	logic [3:0] escape_sq_q;
	logic [15:0] max_iter_q;
	logic [47:0] eps_sq_q;
	mac_pkg::ctrl_t ctl;
	mac_pkg::stat_t st;
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_re_q <= -32'sd536870912;
			start_im_q <= -32'sd301989888;
			pixel_step_q <= 31'd587202;
			escape_sq_q <= 4'd4;
			max_iter_q <= 16'd1000;
			eps_sq_q <= 48'd281474977;
		end else if (wr_en) begin
			case (wr_index)
				mac_pkg::CFG_START_RE:   start_re_q <= wr_data[31:0];
				mac_pkg::CFG_START_IM:   start_im_q <= wr_data[31:0];
				mac_pkg::CFG_PIXEL_STEP: pixel_step_q <= wr_data[30:0];
				mac_pkg::CFG_ESCAPE_SQ:  escape_sq_q <= wr_data[3:0];
				mac_pkg::CFG_MAX_ITER:   max_iter_q <= wr_data[15:0];
				mac_pkg::CFG_EPS_SQ:     eps_sq_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	mac_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.max_iter     (max_iter_q),
		.st           (st),
		.ctl          (ctl),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	mac_dpath u_dpath (
		.clk        (clk),
		.ctl        (ctl),
		.pixel      (pixel),
		.start_re   (start_re_q),
		.start_im   (start_im_q),
		.pixel_step (pixel_step_q),
		.escape_sq  (escape_sq_q),
		.eps_sq     (eps_sq_q),
		.op_a       (op_a),
		.op_b       (op_b),
		.prod_q     (prod_q),
		.st         (st)
	);

	mac_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> !pixel_ready)
		else $error("pixel_ready high right after a pixel beat");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!pixel_ready))
		else $error("result appeared without a pixel in work");

	a_gray_matches_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.gray == mac_pkg::GRAY_ESCAPED) ==
			(result.point_class == mac_pkg::CLASS_ESCAPED)))
		else $error("gray level does not match point class");

	a_no_commit_when_stopping: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !st.cycle_hit && !st.escaped && ctl.iter)
		else $error("iteration committed after a stop condition");
`endif

endmodule

### verif/mandelbrot_attractor_classifier_check.sv
// checker for the attractor classifier: mirrors the registers, predicts each pixel, compares
`timescale 1ns / 100ps

module mandelbrot_attractor_classifier_check (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	input  logic             pixel_ready,
	input  mac_pkg::pixel_t  pixel,
	input  logic             result_valid,
	input  logic             result_ready,
	input  mac_pkg::result_t result,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [47:0]      wr_data,
	output int               pending,
	output int               errors
);

	typedef logic signed [65:0] wide_t;

	localparam wide_t COORD_MAX = 66'sh0_7FFF_FFFF;
	localparam wide_t COORD_MIN = -66'sh0_8000_0000;
	localparam int PRINT_CAP = 100;

	logic signed [31:0] view_re;
	logic signed [31:0] view_im;
	logic [30:0] view_step;
	logic [3:0] escape_bound;
	logic [15:0] iter_limit;
	logic [47:0] cycle_bound;

	mac_pkg::result_t predicted_points[$];
	mac_pkg::result_t want;

	function automatic wide_t clamp32(input wide_t v);
		wide_t r;
		if (v > COORD_MAX) begin
			r = COORD_MAX;
		end else if (v < COORD_MIN) begin
			r = COORD_MIN;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic mac_pkg::result_t classify_point(input mac_pkg::pixel_t px);
		wide_t c_re, c_im, z_re, z_im, d_re, d_im, n_re, n_im, z_bound, d_bound;
		logic [15:0] stop;
		logic [1:0] kind;
		logic done;
		int n;
		mac_pkg::result_t r;
		c_re = clamp32(wide_t'(view_re) + wide_t'(view_step) * wide_t'(px.column));
		c_im = clamp32(wide_t'(view_im) + wide_t'(view_step) * wide_t'(px.row));
		z_re = c_re;
		z_im = c_im;
		d_re = mac_pkg::DERIV_ONE;
		d_im = '0;
		z_bound = wide_t'({escape_bound, 56'd0});
		d_bound = wide_t'(cycle_bound);
		stop = iter_limit;
		kind = mac_pkg::CLASS_LIMIT;
		done = 1'b0;
		for (n = 0; n < int'(iter_limit) && !done; n++) begin
			if (d_re * d_re + d_im * d_im < d_bound) begin
				kind = mac_pkg::CLASS_CYCLE;
				stop = 16'(n);
				done = 1'b1;
			end else if (z_re * z_re + z_im * z_im > z_bound) begin
				kind = mac_pkg::CLASS_ESCAPED;
				stop = 16'(n);
				done = 1'b1;
			end else begin
				// derivative uses the old z
				n_re = clamp32((d_re * z_re - d_im * z_im) >>> (mac_pkg::FRAC_BITS - 1));
				n_im = clamp32((d_re * z_im + d_im * z_re) >>> (mac_pkg::FRAC_BITS - 1));
				d_re = n_re;
				d_im = n_im;
				n_re = clamp32(((z_re * z_re - z_im * z_im) >>> mac_pkg::FRAC_BITS) + c_re);
				n_im = clamp32(((z_re * z_im) >>> (mac_pkg::FRAC_BITS - 1)) + c_im);
				z_re = n_re;
				z_im = n_im;
			end
		end
		r.iterations = stop;
		r.point_class = kind;
		r.gray = (kind == mac_pkg::CLASS_ESCAPED) ? mac_pkg::GRAY_ESCAPED : mac_pkg::GRAY_INSIDE;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input mac_pkg::result_t got,
			input mac_pkg::result_t exp_r);
		if (errors < PRINT_CAP) begin
			$display("%0t mismatch %s: got iter %0d class %0d gray %0d,", $realtime, what,
				got.iterations, got.point_class, got.gray,
				" want iter %0d class %0d gray %0d",
				exp_r.iterations, exp_r.point_class, exp_r.gray);
		end
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_re = -32'sd536870912;
			view_im = -32'sd301989888;
			view_step = 31'd587202;
			escape_bound = 4'd4;
			iter_limit = 16'd1000;
			cycle_bound = 48'd281474977;
			predicted_points.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					mac_pkg::CFG_START_RE: view_re = wr_data[31:0];
					mac_pkg::CFG_START_IM: view_im = wr_data[31:0];
					mac_pkg::CFG_PIXEL_STEP: view_step = wr_data[30:0];
					mac_pkg::CFG_ESCAPE_SQ: escape_bound = wr_data[3:0];
					mac_pkg::CFG_MAX_ITER: iter_limit = wr_data[15:0];
					mac_pkg::CFG_EPS_SQ: cycle_bound = wr_data[47:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (predicted_points.size() == 0) begin
					note_mismatch("result beat with no pixel pending", result, '0);
				end else begin
					want = predicted_points.pop_front();
					if (result.iterations !== want.iterations
							|| result.point_class !== want.point_class
							|| result.gray !== want.gray) begin
						note_mismatch("result fields", result, want);
					end
				end
			end
			if (pixel_valid && pixel_ready) begin
				predicted_points.push_back(classify_point(pixel));
			end
			pending = predicted_points.size();
		end
	end

endmodule

### verif/mandelbrot_attractor_classifier_tb.sv
// testbench top for the attractor classifier: stimulus, idling, watchdog and verdict
`timescale 1ns / 100ps

module mandelbrot_attractor_classifier_tb;

	localparam int STALL_LIMIT = 60000;
	localparam int PHASES = 12;
	localparam int PHASE_PIXELS = 48;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER = 150;
	localparam int TAIL_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_ready;
	mac_pkg::pixel_t pixel;
	logic result_valid;
	logic result_ready;
	mac_pkg::result_t result;
	logic wr_en;
	logic [2:0] wr_index;
	logic [47:0] wr_data;

	int pending;
	int errors;
	int quiet_cycles = 0;
	int results_seen = 0;
	logic gaps_on;
	logic held;

	mandelbrot_attractor_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	mandelbrot_attractor_classifier_check checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.pending(pending),
		.errors(errors)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 80);
	endfunction

	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (result_valid && result_ready) begin
			results_seen <= results_seen + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mandelbrot_attractor_classifier_tb: errors");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold-off
	initial begin : sink
		int gap;
		result_ready = 1'b0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = idle_gap();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(100, 200)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	task automatic send_pixel(input logic [10:0] col, input logic [9:0] row);
		int gap;
		gap = gaps_on ? idle_gap() : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel <= '{column: col, row: row};
		pixel_valid <= 1'b1;
		do @(posedge clk); while (!pixel_ready);
	endtask

	task automatic settle();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [47:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	task automatic load_view(input logic signed [31:0] re, input logic signed [31:0] im,
			input logic [30:0] step, input logic [3:0] esc, input logic [15:0] lim,
			input logic [47:0] eps);
		put_reg(mac_pkg::CFG_START_RE, {16'd0, re});
		put_reg(mac_pkg::CFG_START_IM, {16'd0, im});
		put_reg(mac_pkg::CFG_PIXEL_STEP, {17'd0, step});
		put_reg(mac_pkg::CFG_ESCAPE_SQ, {44'd0, esc});
		put_reg(mac_pkg::CFG_MAX_ITER, {32'd0, lim});
		put_reg(mac_pkg::CFG_EPS_SQ, eps);
		wr_en <= 1'b0;
	endtask

	task automatic random_view();
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [30:0] step;
		logic [3:0] esc;
		logic [15:0] lim;
		logic [47:0] eps;
		int pick;
		re = ($urandom_range(0, 5) == 0) ? $urandom : -$urandom_range(0, 671088640);
		im = ($urandom_range(0, 5) == 0) ? $urandom : -$urandom_range(0, 335544320);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			step = '0;
		end else if (pick == 1) begin
			step = 31'($urandom);
		end else begin
			step = 31'($urandom_range(1 << 16, 1 << 21));
		end
		esc = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd4;
		lim = ($urandom_range(0, 7) == 0) ? 16'd1 : 16'($urandom_range(2, 160));
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			eps = '0;
		end else if (pick == 1) begin
			eps = {16'($urandom), 32'($urandom)};
		end else begin
			eps = 48'($urandom_range(1 << 20, 1 << 30));
		end
		load_view(re, im, step, esc, lim, eps);
	endtask

	task automatic random_pixel();
		logic [10:0] col;
		logic [9:0] row;
		col = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
			: 11'($urandom_range(0, 400));
		row = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(0, 300));
		send_pixel(col, row);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		wr_en = 1'b0;
		wr_index = mac_pkg::CFG_START_RE;
		wr_data = '0;
		gaps_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default view: the first and last pixel of the range and two pixels between them
		send_pixel(11'd0, 10'd0);
		send_pixel(11'd228, 10'd128);
		send_pixel(11'd1279, 10'd719);
		send_pixel(11'd2047, 10'd1023);
		settle();

		// every register at its top, longest limit, points escape at once
		load_view(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 4'd15, 16'hFFFF,
			48'hFFFF_FFFF_FFFF);
		send_pixel(11'd0, 10'd0);
		send_pixel(11'd2047, 10'd1023);
		send_pixel(11'd1, 10'd0);
		settle();

		// bottom start with saturating step, zero limit
		load_view(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 4'd0, 16'd0, 48'd0);
		send_pixel(11'd0, 10'd0);
		send_pixel(11'd2047, 10'd1023);
		send_pixel(11'd1024, 10'd512);
		settle();

		// zero escape radius: origin stays, any other point leaves
		load_view(32'sd0, 32'sd0, 31'd1 << 20, 4'd0, 16'd3, 48'd0);
		send_pixel(11'd0, 10'd0);
		send_pixel(11'd1, 10'd0);
		send_pixel(11'd0, 10'd1);
		settle();

		// c = -1 with zero step: the orbit alternates between -1 and 0, radius on the boundary
		load_view(-32'sd268435456, 32'sd0, 31'd0, 4'd1, 16'd20, 48'd281474977);
		send_pixel(11'd5, 10'd5);
		send_pixel(11'd2047, 10'd1023);
		send_pixel(11'd1023, 10'd511);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			gaps_on = (ph % 4 != 1);
			random_view();
			repeat (PHASE_PIXELS) random_pixel();
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("mandelbrot_attractor_classifier_tb: clean");
		end else begin
			$display("mandelbrot_attractor_classifier_tb: errors");
		end
		$finish;
	end

endmodule
